// ===== hdl/fcfl_pkg.sv =====
// ============================================================================
// fcfl_pkg: shared types and constants for the chunk free-list allocator
// ----------------------------------------------------------------------------
// Holds the request and response payload types, the operation and status
// codes, and the command and status groups that run between the controller
// and the datapath.
// ============================================================================
package fcfl_pkg;

    // Field widths fixed by the interface.
    localparam int IDX_W  = 8;
    localparam int CFG_W  = 9;

    // Default pool size and the chunk_count value after reset.
    localparam int MAX_CHUNKS_DEF = 256;
    localparam int COUNT_RST      = 256;

    // Operation codes carried in the request.
    typedef enum logic [1:0] {
        OP_GET   = 2'd0,
        OP_FREE  = 2'd1,
        OP_ERASE = 2'd2,
        OP_RSVD  = 2'd3
    } t_op;

    // Status codes returned with every response.
    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_ERASED = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_RANGE  = 2'd3
    } t_status;

    // One request item.
    typedef struct packed {
        logic [1:0]       operation;
        logic [IDX_W-1:0] free_index;
    } t_req;

    // One response item.
    typedef struct packed {
        logic [IDX_W-1:0] chunk_index;
        logic [1:0]       status;
    } t_rsp;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic init_clear;   // reload chunk_count, restart the rebuild sweep
        logic sweep_en;     // write one link entry of the rebuild sweep
        logic exec;         // carry out the accepted request
        logic load_head;    // take the fetched link as the new list head
    } t_ctrl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic sweep_last;   // the sweep is at the last link entry
        logic get_ok;       // the pending request is a get that will pop
    } t_dp_stat;

endpackage

// ===== hdl/fcfl_ctrl.sv =====
// ============================================================================
// fcfl_ctrl: sequencing controller of the chunk free-list allocator
// ----------------------------------------------------------------------------
// Runs the link rebuild sweep after reset and after each chunk_count write,
// accepts request items while idle, and after a successful get holds in the
// link load state while the next link is fetched from the link memory.
// ============================================================================
module fcfl_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  fcfl_pkg::t_dp_stat    i_stat,
    output fcfl_pkg::t_ctrl_cmd   o_cmd
);
    import fcfl_pkg::*;

    typedef enum logic [2:0] {
        S_INIT = 3'b001,
        S_IDLE = 3'b010,
        S_LOAD = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   cfg_wr;

    // A pending link load must finish before the pool can be rebuilt, and an
    // item being taken in an idle cycle keeps the write waiting.
    assign o_cfg_ready = (r_state == S_INIT) || ((r_state == S_IDLE) && !start);
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign busy        = (r_state != S_IDLE);

    // Next state and datapath commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        if (cfg_wr) begin
            o_cmd.init_clear = 1'b1;
            n_state          = S_INIT;
        end else begin
            unique case (r_state)
                S_INIT: begin
                    o_cmd.sweep_en = 1'b1;
                    if (i_stat.sweep_last) begin
                        n_state = S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (start) begin
                        o_cmd.exec = 1'b1;
                        if (i_stat.get_ok) begin
                            n_state = S_LOAD;
                        end
                    end
                end
                S_LOAD: begin
                    o_cmd.load_head = 1'b1;
                    n_state         = S_IDLE;
                end
                default: begin
                    n_state = S_INIT;
                end
            endcase
        end
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    // The link load state is always followed directly by the idle state.
    a_load_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD) |=> (r_state == S_IDLE))
        else $error("link load state did not return to idle");

    // The link load state is entered only from a get that pops a chunk.
    a_load_after_get: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD) |-> $past(o_cmd.exec && i_stat.get_ok))
        else $error("link load without a successful get");

    // A configuration write always restarts the rebuild sweep.
    a_cfg_rebuild: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_wr |=> (r_state == S_INIT))
        else $error("configuration write did not start the rebuild");

endmodule

// ===== hdl/fcfl_dpath.sv =====
// ============================================================================
// fcfl_dpath: datapath of the chunk free-list allocator
// ----------------------------------------------------------------------------
// Holds chunk_count, the list head, the erased flag, the link memory with its
// registered read port, the rebuild sweep pointer and the response register.
// ============================================================================
module fcfl_dpath #(
    parameter int MAX_CHUNKS = fcfl_pkg::MAX_CHUNKS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  fcfl_pkg::t_req             i_req,
    input  logic [fcfl_pkg::CFG_W-1:0] i_cfg_data,
    input  fcfl_pkg::t_ctrl_cmd        i_cmd,
    output fcfl_pkg::t_dp_stat         o_stat,
    output logic                       o_done,
    output fcfl_pkg::t_rsp             o_rsp
);
    import fcfl_pkg::*;

    // Index, link and count widths. A link holds an index or the null value.
    localparam int IW = $clog2(MAX_CHUNKS);
    localparam int LW = $clog2(MAX_CHUNKS + 1);
    localparam int CW = (LW > CFG_W) ? LW : CFG_W;
    localparam int RST_COUNT = (COUNT_RST < MAX_CHUNKS) ? COUNT_RST : MAX_CHUNKS;
    localparam logic [LW-1:0] NULL_LINK = LW'(MAX_CHUNKS);
    localparam logic [CW-1:0] MAX_CW    = CW'(MAX_CHUNKS);
    localparam logic [CW-1:0] RST_CW    = CW'(RST_COUNT);
    localparam logic [IW-1:0] LAST_IDX  = IW'(MAX_CHUNKS - 1);

    // Link memory and its registered read data.
    logic [LW-1:0] r_link_mem [MAX_CHUNKS];
    logic [LW-1:0] r_rdata;

    logic [CW-1:0] r_count;
    logic [LW-1:0] r_head;
    logic          r_erased;
    logic [IW-1:0] r_ptr;
    logic          r_done;
    t_rsp          r_rsp;

    logic [CW-1:0] cfg_cw;
    logic [CW-1:0] n_count;
    logic [CW-1:0] idx_cw;
    logic [CW-1:0] head_cw;
    logic [CW-1:0] ptr_next_cw;
    logic [LW-1:0] sweep_link;
    logic          head_ok;
    logic          idx_ok;
    logic          get_ok;
    logic          free_ok;
    logic          erase_set;
    t_status       status;
    logic          mem_we;
    logic [IW-1:0] mem_waddr;
    logic [LW-1:0] mem_wdata;

    // Clamp a written chunk_count to the range 1 .. MAX_CHUNKS.
    assign cfg_cw = CW'(i_cfg_data);
    always_comb begin
        priority if (cfg_cw == '0) begin
            n_count = CW'(1);
        end else if (cfg_cw > MAX_CW) begin
            n_count = MAX_CW;
        end else begin
            n_count = cfg_cw;
        end
    end

    // Range checks against the chunks in use.
    assign idx_cw  = CW'(i_req.free_index);
    assign head_cw = CW'(r_head);
    assign head_ok = (head_cw < r_count);
    assign idx_ok  = (idx_cw < r_count);

    // Decode the request into its effect and its status.
    always_comb begin
        get_ok    = 1'b0;
        free_ok   = 1'b0;
        erase_set = 1'b0;
        status    = ST_OK;
        priority if (i_req.operation == OP_RSVD) begin
            status = ST_OK;
        end else if (r_erased) begin
            status = ST_ERASED;
        end else begin
            unique case (t_op'(i_req.operation))
                OP_GET: begin
                    if (head_ok) begin
                        get_ok = 1'b1;
                    end else begin
                        status = ST_EMPTY;
                    end
                end
                OP_FREE: begin
                    if (idx_ok) begin
                        free_ok = 1'b1;
                    end else begin
                        status = ST_RANGE;
                    end
                end
                default: begin
                    erase_set = 1'b1;
                end
            endcase
        end
    end

    assign o_stat.get_ok     = get_ok;
    assign o_stat.sweep_last = (r_ptr == LAST_IDX);

    // Rebuild value: each chunk links to the next one in use, the last to null.
    assign ptr_next_cw = CW'(r_ptr) + CW'(1);
    assign sweep_link  = (ptr_next_cw < r_count) ? ptr_next_cw[LW-1:0] : NULL_LINK;

    // Link memory write port: the rebuild sweep or the push of a freed chunk.
    assign mem_we    = i_cmd.sweep_en || (i_cmd.exec && free_ok);
    assign mem_waddr = i_cmd.sweep_en ? r_ptr : idx_cw[IW-1:0];
    assign mem_wdata = i_cmd.sweep_en ? sweep_link : r_head;

    // Link memory, read at the current head every cycle.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_link_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_link_mem[r_head[IW-1:0]];
    end

    // Pool control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= RST_CW;
            r_head   <= '0;
            r_erased <= 1'b0;
            r_ptr    <= '0;
            r_done   <= 1'b0;
        end else begin
            r_done <= i_cmd.exec;
            if (i_cmd.init_clear) begin
                r_count  <= n_count;
                r_head   <= '0;
                r_erased <= 1'b0;
                r_ptr    <= '0;
            end else begin
                if (i_cmd.sweep_en) begin
                    r_ptr <= r_ptr + IW'(1);
                end
                if (i_cmd.exec && free_ok) begin
                    r_head <= idx_cw[LW-1:0];
                end
                if (i_cmd.exec && erase_set) begin
                    r_erased <= 1'b1;
                end
                if (i_cmd.load_head) begin
                    r_head <= r_rdata;
                end
            end
        end
    end

    // Response register, loaded as each item is accepted.
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_rsp.chunk_index <= get_ok ? head_cw[IDX_W-1:0] : '0;
            r_rsp.status      <= status;
        end
    end

    assign o_done = r_done;
    assign o_rsp  = r_rsp;

    // The head is always a chunk in use or the null link.
    a_head_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (head_cw < r_count) || (r_head == NULL_LINK))
        else $error("list head outside the pool");

    // chunk_count stays within 1 .. MAX_CHUNKS.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) && (r_count <= MAX_CW))
        else $error("chunk_count out of range");

    // A popped chunk is reported with status ok.
    a_pop_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && get_ok) |=> (o_done && (o_rsp.status == ST_OK)))
        else $error("successful get not reported as ok");

endmodule

// ===== hdl/fixed_chunk_free_list_allocator.sv =====
// ============================================================================
// fixed_chunk_free_list_allocator: fixed-size chunk pool kept as a free list
// ----------------------------------------------------------------------------
// Hands out and takes back chunk indexes from a linked free list held in an
// on-chip link memory, with an erase command and a chunk_count register.
// ============================================================================
// Usage: an item is taken at a clock edge with start high and busy low. Its
// response appears on o_rsp in the cycle after the item is taken, marked by
// o_done for exactly one cycle; the receiver cannot stall it, so it must be
// captured then. A get that pops a chunk keeps the block busy in the link
// load state, because the chunk's next link is read from the synchronous link
// memory before the head can move on; every other item leaves the block idle.
// After reset and after each chunk_count write the block rebuilds the list by
// writing every link entry, one per cycle, and holds busy high until it is done.
// chunk_count may only be written while no item is in progress.
module fixed_chunk_free_list_allocator #(
    parameter int MAX_CHUNKS = fcfl_pkg::MAX_CHUNKS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  fcfl_pkg::t_req             i_req,
    output logic                       o_done,
    output fcfl_pkg::t_rsp             o_rsp,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [fcfl_pkg::CFG_W-1:0] i_cfg_data
);
    import fcfl_pkg::*;

    t_ctrl_cmd cmd;
    t_dp_stat  stat;

    // Sequencing controller.
    fcfl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // Free-list datapath and link memory.
    fcfl_dpath #(
        .MAX_CHUNKS (MAX_CHUNKS)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (i_req),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_done     (o_done),
        .o_rsp      (o_rsp)
    );

endmodule

// ===== sim/fixed_chunk_free_list_allocator_tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// fixed_chunk_free_list_allocator_tb: self-checking bench for the allocator
// ----------------------------------------------------------------------------
// Drives get, free, erase and reserved requests through the start/busy port
// and predicts every response from a local copy of the free list, its head,
// the erase flag and the pool size. Responses are checked field by field as
// they are strobed out. The pool size register is rewritten between phases,
// including the clamped extremes, and the sender idles at several rates.
// ============================================================================
module fixed_chunk_free_list_allocator_tb;
    import fcfl_pkg::*;

    localparam int POOL      = MAX_CHUNKS_DEF;
    localparam int CYCLE_CAP = 200000;
    localparam int SETTLE    = 4;
    localparam int PHASES    = 12;
    localparam int PHASE_LEN = 118;
    localparam int COUNT_PLAN [PHASES] = '{256, 3, 1, 511, 2, 255, 8, 257, 0, 5, 0, 0};

    // Scoreboard: mirrors the free list and holds the responses still owed.
    class chunk_pool_scoreboard;
        logic [CFG_W-1:0] link_mem [POOL];
        logic [CFG_W-1:0] head_ptr;
        logic [CFG_W-1:0] pool_size;
        logic             pool_erased;
        t_rsp             awaited_rsp [$];
        int               n_fail;
        int               n_checked;
        int               n_status [4];

        function new();
            load_count(CFG_W'(COUNT_RST));
        endfunction

        // A size write clamps the value, rebuilds the chain and clears erase.
        function void load_count(logic [CFG_W-1:0] v);
            pool_size = v;
            if (v == 0) pool_size = 1;
            if (v > POOL) pool_size = POOL;
            for (int i = 0; i < POOL; i++) begin
                link_mem[i] = (i + 1 < pool_size) ? CFG_W'(i + 1) : CFG_W'(POOL);
            end
            head_ptr    = '0;
            pool_erased = 1'b0;
        endfunction

        // Apply one accepted request to the mirror and queue its response.
        function t_rsp take_request(t_req r);
            t_rsp ans;
            ans.chunk_index = '0;
            ans.status      = ST_OK;
            if (t_op'(r.operation) == OP_RSVD) begin
                ans.status = ST_OK;
            end else if (pool_erased) begin
                ans.status = ST_ERASED;
            end else begin
                case (t_op'(r.operation))
                    OP_GET: begin
                        if (head_ptr >= pool_size || head_ptr >= POOL) begin
                            ans.status = ST_EMPTY;
                        end else begin
                            ans.chunk_index = head_ptr[IDX_W-1:0];
                            head_ptr        = link_mem[head_ptr[IDX_W-1:0]];
                        end
                    end
                    OP_FREE: begin
                        if (CFG_W'(r.free_index) >= pool_size) begin
                            ans.status = ST_RANGE;
                        end else begin
                            link_mem[r.free_index] = head_ptr;
                            head_ptr               = CFG_W'(r.free_index);
                        end
                    end
                    default: begin
                        pool_erased = 1'b1;
                    end
                endcase
            end
            awaited_rsp.push_back(ans);
            return ans;
        endfunction

        function void flag(string what);
            n_fail++;
            if (n_fail <= 10) $display("[%0t] mismatch: %s", $time, what);
        endfunction

        // Compare a strobed response with the oldest one owed.
        function void check_response(t_rsp got);
            t_rsp want;
            if (awaited_rsp.size() == 0) begin
                flag($sformatf("response with none pending: chunk_index %0d status %0d",
                               got.chunk_index, got.status));
                return;
            end
            want = awaited_rsp.pop_front();
            n_checked++;
            n_status[want.status]++;
            if (got.chunk_index !== want.chunk_index) begin
                flag($sformatf("chunk_index expected %0d got %0d",
                               want.chunk_index, got.chunk_index));
            end
            if (got.status !== want.status) begin
                flag($sformatf("status expected %0d got %0d", want.status, got.status));
            end
        endfunction

        function void close_out();
            if (awaited_rsp.size() != 0) begin
                flag($sformatf("%0d responses never arrived", awaited_rsp.size()));
            end
        endfunction
    endclass

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             start       = 1'b0;
    t_req             i_req       = '0;
    logic             i_cfg_valid = 1'b0;
    logic [CFG_W-1:0] i_cfg_data  = '0;
    logic             busy;
    logic             o_done;
    t_rsp             o_rsp;
    logic             o_cfg_ready;

    chunk_pool_scoreboard sb;
    logic [IDX_W-1:0]     held [$];
    int                   n_sent;
    int                   n_cfg;
    int                   cycle_cnt;

    fixed_chunk_free_list_allocator DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_done      (o_done),
        .o_rsp       (o_rsp),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Responses cannot be held off, so each strobe is checked on the spot.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done !== 1'b0) sb.check_response(o_rsp);
    end

    // Watchdog against a hung handshake.
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt == CYCLE_CAP) begin
            $display("run stopped after %0d cycles", CYCLE_CAP);
            $display("fixed_chunk_free_list_allocator_tb: FAIL");
            $finish;
        end
    end

    // Send one item, idling first at the given percentage per cycle.
    task automatic issue(input t_op op, input logic [IDX_W-1:0] idx, input int idle_pct);
        t_req r;
        t_rsp ans;
        r.operation  = op;
        r.free_index = idx;
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy !== 1'b0);
        ans = sb.take_request(r);
        n_sent++;
        if (op == OP_GET && ans.status == ST_OK) held.push_back(ans.chunk_index);
    endtask

    // Stop sending and let every owed response come out.
    task automatic drain();
        start <= 1'b0;
        while (sb.awaited_rsp.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_count(input logic [CFG_W-1:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        i_cfg_valid <= 1'b0;
        sb.load_count(v);
        held.delete();
        n_cfg++;
    endtask

    // Mostly gets and frees of chunks handed out earlier, with some stray
    // and out-of-range frees, reserved codes, and erases near the end.
    task automatic random_phase(input int n_items, input int idle_pct);
        int               roll;
        int               sel;
        int               k;
        logic [IDX_W-1:0] idx;
        t_op              op;
        for (int i = 0; i < n_items; i++) begin
            roll = $urandom_range(99);
            idx  = IDX_W'($urandom_range(255));
            if (i >= n_items - n_items / 10 && roll < 6) begin
                op = OP_ERASE;
            end else if (roll < 3) begin
                op = OP_RSVD;
            end else if (roll < 52) begin
                op = OP_GET;
            end else begin
                op  = OP_FREE;
                sel = $urandom_range(9);
                if (held.size() != 0 && sel < 7) begin
                    k   = $urandom_range(held.size() - 1);
                    idx = held[k];
                    held.delete(k);
                end else if (sel < 9) begin
                    idx = IDX_W'($urandom_range(int'(sb.pool_size) - 1));
                end
            end
            issue(op, idx, idle_pct);
        end
        drain();
    endtask

    initial begin
        logic [CFG_W-1:0] cnt;
        int               pct;
        sb = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Full pool after reset: pops, pushes at both ends, reserved codes.
        issue(OP_GET, 8'h00, 0);
        issue(OP_GET, 8'hFF, 0);
        issue(OP_FREE, 8'h00, 0);
        issue(OP_GET, 8'h00, 0);
        issue(OP_FREE, 8'hFF, 0);
        issue(OP_GET, 8'h00, 0);
        issue(OP_RSVD, 8'hFF, 0);
        issue(OP_RSVD, 8'h00, 0);
        drain();

        // Two chunks: empty list, range errors, double free, erase lockout.
        write_count(9'd2);
        issue(OP_GET, 8'h00, 0);
        issue(OP_GET, 8'h00, 0);
        issue(OP_GET, 8'h00, 0);
        issue(OP_FREE, 8'h02, 0);
        issue(OP_FREE, 8'hFF, 0);
        issue(OP_FREE, 8'h01, 0);
        issue(OP_FREE, 8'h01, 0);
        issue(OP_GET, 8'h00, 0);
        issue(OP_GET, 8'h00, 0);
        issue(OP_ERASE, 8'h00, 0);
        issue(OP_GET, 8'h00, 0);
        issue(OP_FREE, 8'h00, 0);
        issue(OP_ERASE, 8'h00, 0);
        issue(OP_RSVD, 8'h00, 0);
        drain();

        // A zero write is taken as a single chunk.
        write_count(9'd0);
        issue(OP_GET, 8'h00, 0);
        issue(OP_GET, 8'h00, 0);
        issue(OP_FREE, 8'h00, 0);
        issue(OP_FREE, 8'h01, 0);
        drain();

        // Random phases over several pool sizes and idle rates.
        for (int p = 0; p < PHASES; p++) begin
            if (p == PHASES - 2) cnt = CFG_W'($urandom_range(1, 32));
            else if (p == PHASES - 1) cnt = CFG_W'($urandom_range(511));
            else cnt = CFG_W'(COUNT_PLAN[p]);
            case (p % 3)
                0:       pct = 0;
                1:       pct = 86;
                default: pct = 8;
            endcase
            write_count(cnt);
            random_phase(PHASE_LEN, pct);
        end

        sb.close_out();
        $display("Sent %0d items over %0d pool size writes; %0d responses checked.",
                 n_sent, n_cfg, sb.n_checked);
        $display("Answers seen: %0d ok, %0d erased, %0d empty, %0d out of range; %0d mismatches.",
                 sb.n_status[ST_OK], sb.n_status[ST_ERASED], sb.n_status[ST_EMPTY],
                 sb.n_status[ST_RANGE], sb.n_fail);
        if (sb.n_fail == 0) begin
            $display("fixed_chunk_free_list_allocator_tb: PASS");
        end else begin
            $display("fixed_chunk_free_list_allocator_tb: FAIL");
        end
        $finish;
    end

endmodule
